[rtl/core/spr_pkg.sv]
// Package for the four-channel setpoint ramp core.
// Holds request/response payload types, the sequencer state type and sizing constants.
// No dependencies.
`default_nettype none

package spr_pkg;

    localparam int SPR_CHANNELS = 4;
    localparam int SPR_CH_W     = $clog2(SPR_CHANNELS);
    localparam int SPR_VAL_W    = 16;
    localparam int SPR_STEP_W   = SPR_VAL_W + 1;
    localparam int SPR_SUM_W    = SPR_VAL_W + 2;
    localparam int SPR_CNT_W    = 8;
    localparam int SPR_QW       = 16;
    localparam int SPR_QCNT_W   = $clog2(SPR_QW);

    localparam logic [SPR_CNT_W-1:0] SPR_RAMP_RST = 8'd10;

    typedef struct packed {
        logic signed [SPR_VAL_W-1:0] target_3;
        logic signed [SPR_VAL_W-1:0] target_2;
        logic signed [SPR_VAL_W-1:0] target_1;
        logic signed [SPR_VAL_W-1:0] target_0;
    } t_spr_req;

    typedef struct packed {
        logic signed [SPR_VAL_W-1:0] drive_3;
        logic signed [SPR_VAL_W-1:0] drive_2;
        logic signed [SPR_VAL_W-1:0] drive_1;
        logic signed [SPR_VAL_W-1:0] drive_0;
    } t_spr_rsp;

    typedef struct packed {
        logic                  start;
        logic                  neg;
        logic [SPR_QW-1:0]     dividend;
        logic [SPR_CNT_W-1:0]  divisor;
    } t_spr_div_cmd;

    typedef struct packed {
        logic                         done;
        logic signed [SPR_STEP_W-1:0] quot;
    } t_spr_div_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } t_spr_state;

endpackage

`default_nettype wire

[rtl/core/spr_divider.sv]
// Shared restoring divider: unsigned 16-bit magnitude by 8-bit divisor, one bit per cycle.
// Quotient is negated on completion for a truncate-toward-zero signed result.
// Depends on spr_pkg.
`default_nettype none

module spr_divider
    import spr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_spr_div_cmd i_cmd,
    output t_spr_div_rsp      o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic                  r_neg;
    logic [SPR_QCNT_W-1:0] r_cnt;
    logic [SPR_CNT_W-1:0]  r_rem;
    logic [SPR_QW-1:0]     r_quo;
    logic [SPR_CNT_W-1:0]  r_div;

    logic [SPR_CNT_W:0]    w_shift;
    logic [SPR_CNT_W:0]    w_diff;
    logic                  w_ge;
    logic [SPR_STEP_W-1:0] w_mag;

    assign w_shift = {r_rem, r_quo[SPR_QW-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_mag   = {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SPR_QCNT_W'(SPR_QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= '0;
            r_quo <= i_cmd.dividend;
            r_div <= i_cmd.divisor;
            r_neg <= i_cmd.neg;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SPR_CNT_W-1:0] : w_shift[SPR_CNT_W-1:0];
            r_quo <= {r_quo[SPR_QW-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -w_mag : w_mag;

endmodule

`default_nettype wire

[rtl/core/setpoint_ramp_four_channel_core.sv]
// Top level of the four-channel setpoint ramp core: sequencer, channel state, output register.
// Depends on spr_pkg and spr_divider.
//
//   channel  signals                              payload
//   req      i_req_valid / o_req_ready            i_req  (t_spr_req, four targets)
//   rsp      o_rsp_valid / i_rsp_ready            o_rsp  (t_spr_rsp, four drives)
//   cfg      i_cfg_valid / o_cfg_ready            i_cfg_data (ramp_steps, 8 bit)
//
// Channels are processed one after another. An unchanged target is settled in ST_EVAL; a
// changed target also passes through ST_DIV (one bit per cycle in the shared divider). ST_OUT
// then loads the response register once it is free, and the sequencer returns to ST_IDLE.
// Synchronous active-low reset clears channel state except latched targets; ramp_steps resets to 10.
// A held response does not block the next request; it waits only at the final load.
`default_nettype none

module setpoint_ramp_four_channel_core
    import spr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    output logic                      o_req_ready,
    input  wire t_spr_req             i_req,
    output logic                      o_rsp_valid,
    input  wire logic                 i_rsp_ready,
    output t_spr_rsp                  o_rsp,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [SPR_CNT_W-1:0] i_cfg_data
);

    t_spr_state r_state, n_state;

    logic [SPR_CNT_W-1:0]         r_ramp;
    logic [SPR_CH_W-1:0]          r_ch, n_ch;
    logic signed [SPR_VAL_W-1:0]  r_tgt   [SPR_CHANNELS];
    logic signed [SPR_VAL_W-1:0]  n_tgt   [SPR_CHANNELS];
    logic signed [SPR_VAL_W-1:0]  r_last  [SPR_CHANNELS];
    logic signed [SPR_VAL_W-1:0]  n_last  [SPR_CHANNELS];
    logic signed [SPR_VAL_W-1:0]  r_drive [SPR_CHANNELS];
    logic signed [SPR_VAL_W-1:0]  n_drive [SPR_CHANNELS];
    logic signed [SPR_STEP_W-1:0] r_step  [SPR_CHANNELS];
    logic signed [SPR_STEP_W-1:0] n_step  [SPR_CHANNELS];
    logic [SPR_CNT_W-1:0]         r_steps [SPR_CHANNELS];
    logic [SPR_CNT_W-1:0]         n_steps [SPR_CHANNELS];
    t_spr_rsp                     r_rsp, n_rsp;
    logic                         r_rsp_valid, n_rsp_valid;

    logic [SPR_CNT_W-1:0]         w_n;
    logic signed [SPR_VAL_W-1:0]  w_t;
    logic signed [SPR_VAL_W-1:0]  w_d;
    logic                         w_same;
    logic                         w_below;
    logic                         w_last_ch;
    logic                         w_load;
    logic signed [SPR_STEP_W-1:0] w_gap;
    logic [SPR_STEP_W-1:0]        w_gap_mag;
    logic signed [SPR_STEP_W-1:0] w_add;
    logic signed [SPR_SUM_W-1:0]  w_sum;
    logic signed [SPR_VAL_W-1:0]  w_sat;
    t_spr_div_cmd                 w_div_cmd;
    t_spr_div_rsp                 w_div_rsp;

    spr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_rsp   (w_div_rsp)
    );

    assign w_n       = (r_ramp == '0) ? SPR_CNT_W'(1) : r_ramp;
    assign w_t       = r_tgt[r_ch];
    assign w_d       = r_drive[r_ch];
    assign w_same    = (w_t == r_last[r_ch]);
    assign w_below   = (r_steps[r_ch] < w_n);
    assign w_last_ch = (r_ch == SPR_CH_W'(SPR_CHANNELS - 1));
    assign w_load    = !r_rsp_valid || i_rsp_ready;

    assign w_gap     = SPR_STEP_W'(w_t) - SPR_STEP_W'(w_d);
    assign w_gap_mag = w_gap[SPR_STEP_W-1] ? -w_gap : w_gap;

    // one adder serves both the hold-ramp step and the freshly divided step
    assign w_add = (r_state == ST_DIV) ? w_div_rsp.quot : r_step[r_ch];
    assign w_sum = SPR_SUM_W'(w_d) + SPR_SUM_W'(w_add);

    always_comb begin
        if (w_sum > SPR_SUM_W'(32767)) begin
            w_sat = 16'sh7FFF;
        end else if (w_sum < -SPR_SUM_W'(32768)) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_sum[SPR_VAL_W-1:0];
        end
    end

    assign w_div_cmd.start    = (r_state == ST_EVAL) && !w_same;
    assign w_div_cmd.neg      = w_gap[SPR_STEP_W-1];
    assign w_div_cmd.dividend = w_gap_mag[SPR_QW-1:0];
    assign w_div_cmd.divisor  = w_n;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!w_same) begin
                    n_state = ST_DIV;
                end else if (w_last_ch) begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = w_last_ch ? ST_OUT : ST_EVAL;
                end
            end
            ST_OUT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        o_req_ready     = (r_state == ST_IDLE);
        n_ch            = r_ch;
        n_tgt           = r_tgt;
        n_last          = r_last;
        n_drive         = r_drive;
        n_step          = r_step;
        n_steps         = r_steps;
        n_rsp           = r_rsp;
        n_rsp_valid     = r_rsp_valid;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_tgt[0] = i_req.target_0;
                    n_tgt[1] = i_req.target_1;
                    n_tgt[2] = i_req.target_2;
                    n_tgt[3] = i_req.target_3;
                    n_ch     = '0;
                end
            end
            ST_EVAL: begin
                if (w_same) begin
                    if (w_below) begin
                        n_drive[r_ch] = w_sat;
                        n_steps[r_ch] = r_steps[r_ch] + 1'b1;
                    end
                    n_ch = r_ch + 1'b1;
                end
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_step[r_ch]  = w_div_rsp.quot;
                    n_drive[r_ch] = w_sat;
                    n_steps[r_ch] = SPR_CNT_W'(1);
                    n_last[r_ch]  = w_t;
                    n_ch          = r_ch + 1'b1;
                end
            end
            ST_OUT: begin
                if (w_load) begin
                    n_rsp.drive_0 = r_drive[0];
                    n_rsp.drive_1 = r_drive[1];
                    n_rsp.drive_2 = r_drive[2];
                    n_rsp.drive_3 = r_drive[3];
                    n_rsp_valid   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_rsp_valid <= 1'b0;
            for (int k = 0; k < SPR_CHANNELS; k++) begin
                r_last[k]  <= '0;
                r_drive[k] <= '0;
                r_step[k]  <= '0;
                r_steps[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_rsp_valid <= n_rsp_valid;
            r_last      <= n_last;
            r_drive     <= n_drive;
            r_step      <= n_step;
            r_steps     <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt <= n_tgt;
        r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp <= SPR_RAMP_RST;
        end else if (i_cfg_valid) begin
            r_ramp <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_div_start_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_cmd.start |-> (r_state == ST_EVAL) && !w_same)
        else $error("divider started outside channel evaluation");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider result arrived while sequencer not waiting");

    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request accepted while previous one still in progress");

    a_rsp_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && w_load) |=> o_rsp_valid && (r_state == ST_IDLE))
        else $error("response not presented after final channel");

endmodule

`default_nettype wire

[bench/setpoint_ramp_four_channel_core_tb.sv]
// Self-checking bench for setpoint_ramp_four_channel_core: directed ramps, then random requests.
// Runs with random idling on both sides and ramp_steps changes between phases.
// Depends on spr_pkg and the core RTL.
module setpoint_ramp_four_channel_core_tb
    import spr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 2000;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES      = 8;
    localparam int PHASE_REQS  = 50;
    localparam int DRAIN_WAIT  = 80;

    class ramp_scoreboard;
        logic [SPR_CNT_W-1:0]         steps_cfg;
        logic signed [SPR_VAL_W-1:0]  prev_tgt [SPR_CHANNELS];
        logic signed [SPR_VAL_W-1:0]  drive [SPR_CHANNELS];
        logic signed [SPR_STEP_W-1:0] step [SPR_CHANNELS];
        logic [SPR_CNT_W-1:0]         taken [SPR_CHANNELS];
        t_spr_rsp                     drive_q[$];
        int unsigned                  errors;

        function new();
            steps_cfg = SPR_RAMP_RST;
            errors    = 0;
            for (int c = 0; c < SPR_CHANNELS; c++) begin
                prev_tgt[c] = '0;
                drive[c]    = '0;
                step[c]     = '0;
                taken[c]    = '0;
            end
        endfunction

        function void set_steps(logic [SPR_CNT_W-1:0] v);
            steps_cfg = v;
        endfunction

        function void note_req(t_spr_req r);
            int n;
            int t;
            int sum;
            t_spr_rsp want;
            n = (steps_cfg == 0) ? 1 : int'(steps_cfg);
            for (int c = 0; c < SPR_CHANNELS; c++) begin
                t = int'(signed'(r[c*SPR_VAL_W +: SPR_VAL_W]));
                if (t == int'(prev_tgt[c])) begin
                    if (int'(taken[c]) < n) begin
                        sum = int'(drive[c]) + int'(step[c]);
                        drive[c] = (sum > 32767) ? 16'sh7FFF :
                                   (sum < -32768) ? 16'sh8000 : sum[SPR_VAL_W-1:0];
                        taken[c] = taken[c] + 1'b1;
                    end
                end else begin
                    step[c] = SPR_STEP_W'((t - int'(drive[c])) / n);
                    sum = int'(drive[c]) + int'(step[c]);
                    drive[c] = (sum > 32767) ? 16'sh7FFF :
                               (sum < -32768) ? 16'sh8000 : sum[SPR_VAL_W-1:0];
                    taken[c] = 8'd1;
                end
                prev_tgt[c] = t[SPR_VAL_W-1:0];
                want[c*SPR_VAL_W +: SPR_VAL_W] = drive[c];
            end
            drive_q.push_back(want);
        endfunction

        function void check_rsp(t_spr_rsp got);
            t_spr_rsp want;
            if (drive_q.size() == 0) begin
                $error("unexpected response %h", got);
                errors++;
                return;
            end
            want = drive_q.pop_front();
            for (int c = 0; c < SPR_CHANNELS; c++) begin
                if (got[c*SPR_VAL_W +: SPR_VAL_W] !== want[c*SPR_VAL_W +: SPR_VAL_W]) begin
                    $error("drive_%0d: expected %0d, actual %0d", c,
                           $signed(want[c*SPR_VAL_W +: SPR_VAL_W]),
                           $signed(got[c*SPR_VAL_W +: SPR_VAL_W]));
                    errors++;
                end
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_req_valid;
    logic                 o_req_ready;
    t_spr_req             i_req;
    logic                 o_rsp_valid;
    logic                 i_rsp_ready;
    t_spr_rsp             o_rsp;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [SPR_CNT_W-1:0] i_cfg_data;

    ramp_scoreboard              sb;
    bit                          hold_off_go;
    bit                          no_idle;
    logic signed [SPR_VAL_W-1:0] cur_tgt [SPR_CHANNELS];

    setpoint_ramp_four_channel_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // handshake monitor and stall watchdog
    initial begin : monitor
        int unsigned quiet;
        bit          moved;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            moved = 1'b0;
            if (i_rst_n) begin
                if (o_rsp_valid && i_rsp_ready) begin
                    sb.check_rsp(o_rsp);
                    moved = 1'b1;
                end
                if (i_req_valid && o_req_ready) begin
                    sb.note_req(i_req);
                    moved = 1'b1;
                end
                if (i_cfg_valid && o_cfg_ready) begin
                    sb.set_steps(i_cfg_data);
                    moved = 1'b1;
                end
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $error("no handshake for %0d cycles", quiet);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : rsp_sink
        int unsigned stall_left;
        bit          hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        i_rsp_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_go && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !no_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    task automatic send_targets(input logic signed [SPR_VAL_W-1:0] t0, t1, t2, t3);
        i_req_valid <= 1'b1;
        i_req       <= {t3, t2, t1, t0};
        do @(posedge i_clk); while (!o_req_ready);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_steps(input logic [SPR_CNT_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [SPR_CNT_W-1:0] phase_steps [PHASES];
        bit                   noise;
        sb          = new();
        hold_off_go = 1'b0;
        no_idle     = 1'b0;
        for (int c = 0; c < SPR_CHANNELS; c++) cur_tgt[c] = '0;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero targets right after reset count as unchanged
        send_targets(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_targets(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        repeat (3) send_targets(16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1);
        send_targets(16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1);

        write_steps(8'd0);
        repeat (2) send_targets(16'sd100, -16'sd100, 16'sh7FFF, 16'sh8000);

        // full-scale steps, then a longer count while held drives into saturation
        write_steps(8'd1);
        send_targets(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_targets(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
        write_steps(8'd255);
        repeat (3) send_targets(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
        send_targets(16'sd0, 16'sd0, 16'sd0, 16'sd0);

        phase_steps = '{8'd3, 8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd0, 8'd128,
                        8'($urandom_range(2, 254)), 8'd10};
        for (int p = 0; p < PHASES; p++) begin
            write_steps(phase_steps[p]);
            if (p == 1) hold_off_go = 1'b1;
            if (p == PHASES - 1) no_idle = 1'b1;
            for (int k = 0; k < PHASE_REQS; k++) begin
                noise = ($urandom_range(0, 9) == 0);
                for (int c = 0; c < SPR_CHANNELS; c++) begin
                    if (noise || $urandom_range(0, 4) == 0) begin
                        case ($urandom_range(0, 7))
                            0:       cur_tgt[c] = 16'sh7FFF;
                            1:       cur_tgt[c] = 16'sh8000;
                            2:       cur_tgt[c] = 16'sd0;
                            3:       cur_tgt[c] = -16'sd1;
                            default: cur_tgt[c] = 16'($urandom());
                        endcase
                    end
                end
                send_targets(cur_tgt[0], cur_tgt[1], cur_tgt[2], cur_tgt[3]);
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
